[rtl/dbd_pkg.sv]
`default_nettype none
package dbd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CUM_W   = 9;
  localparam int unsigned Q100_W  = 8;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd3652058;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Month length; February gets the leap day here.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      MON_FEB:                             n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:  n = 5'd30;
      default:                             n = 5'd31;
    endcase
    return n;
  endfunction

  // Days in the months before m, common year.
  function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] c;
    unique case (m)
      MON_FEB: c = 9'd31;
      MON_MAR: c = 9'd59;
      MON_APR: c = 9'd90;
      MON_MAY: c = 9'd120;
      MON_JUN: c = 9'd151;
      MON_JUL: c = 9'd181;
      MON_AUG: c = 9'd212;
      MON_SEP: c = 9'd243;
      MON_OCT: c = 9'd273;
      MON_NOV: c = 9'd304;
      MON_DEC: c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/dbd_day_num.sv]
`default_nettype none
module dbd_day_num
  import dbd_pkg::*;
(
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [DAY_W-1:0]   day,
  output logic [COUNT_W-1:0]      day_num,
  output logic                    date_ok
);

  // stage 1: year - 1, reciprocal products, range checks
  logic [YEAR_W-1:0]  py1_r, y1_r;
  logic [MONTH_W-1:0] m1_r;
  logic [DAY_W-1:0]   d1_r;
  logic               yok1_r, mok1_r;
  logic [PROD_W-1:0]  pyprod1_r, yprod1_r;
  logic [YEAR_W-1:0]  py1_nxt;

  assign py1_nxt = year - YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      py1_r     <= py1_nxt;
      y1_r      <= year;
      m1_r      <= month;
      d1_r      <= day;
      yok1_r    <= (year != '0) && (year <= YEAR_MAX);
      mok1_r    <= (month >= MON_JAN) && (month <= MON_DEC);
      pyprod1_r <= PROD_W'(py1_nxt) * PROD_W'(RECIP_100);
      yprod1_r  <= PROD_W'(year) * PROD_W'(RECIP_100);
    end
  end

  // stage 2: quotients, leap rule, day check, month offset
  logic [Q100_W-1:0]  pyq, yq;
  logic [6:0]         yrem;
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic [YEAR_W-1:0]  py2_r;
  logic [Q100_W-1:0]  q2_r;
  logic [CUM_W-1:0]   cum2_r;
  logic [DAY_W-1:0]   d2_r;
  logic               ok2_r;

  assign pyq  = pyprod1_r[RECIP_SHIFT +: Q100_W];
  assign yq   = yprod1_r[RECIP_SHIFT +: Q100_W];
  assign yrem = 7'(y1_r - YEAR_W'(yq) * YEAR_W'(100));
  assign leap = (y1_r[1:0] == 2'd0) && ((yrem != 7'd0) || (yq[1:0] == 2'd0));
  assign dim  = month_len(m1_r, leap);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      py2_r  <= py1_r;
      q2_r   <= pyq;
      cum2_r <= month_cum(m1_r) + CUM_W'(leap && (m1_r > MON_FEB));
      d2_r   <= d1_r;
      ok2_r  <= yok1_r && mok1_r && (d1_r != '0) && (d1_r <= dim);
    end
  end

  // stage 3: day number counted from 0001-01-01
  logic [COUNT_W-1:0] num_r;
  logic               ok3_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      num_r <= COUNT_W'(py2_r) * COUNT_W'(365) + COUNT_W'(py2_r >> 2)
               - COUNT_W'(q2_r) + COUNT_W'(q2_r >> 2)
               + COUNT_W'(cum2_r) + COUNT_W'(d2_r) - COUNT_W'(1);
      ok3_r <= ok2_r;
    end
  end

  assign day_num = num_r;
  assign date_ok = ok3_r;

endmodule
`default_nettype wire

[rtl/days_between_dates_unit.sv]
`default_nettype none
// Day difference between two proleptic Gregorian dates (4/100/400 leap rule).
// Each transaction carries a reference date and an earlier date; the result
// is the number of days from the earlier date to the reference date, with
// tuser high when both dates are valid and the earlier one is not after the
// reference. Otherwise tuser is low and the count is 0. One transaction per
// cycle is accepted while the pipeline is not stalled; each one passes
// through three day number stages per date, run side by side, then the
// subtract/output stage. Stalls back up stage by stage, so the input keeps
// taking transactions while any stage holds a bubble.
module days_between_dates_unit
  import dbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [13:0] ref_year, [17:14] ref_month, [22:18] ref_day,
  // [36:23] start_year, [40:37] start_month, [45:41] start_day, [47:46] zero
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [21:0] day_count, [23:22] zero
  output logic [23:0]      out_tdata,
  // [0] dates_ok
  output logic [0:0]       out_tuser
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign en.s1 = in_tvalid && rdy1;
  assign en.s2 = v1_r && rdy2;
  assign en.s3 = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  logic [COUNT_W-1:0] ref_num, start_num;
  logic               ref_ok, start_ok;

  dbd_day_num u_ref (
    .clk     (clk),
    .en      (en),
    .year    (in_tdata[13:0]),
    .month   (in_tdata[17:14]),
    .day     (in_tdata[22:18]),
    .day_num (ref_num),
    .date_ok (ref_ok)
  );

  dbd_day_num u_start (
    .clk     (clk),
    .en      (en),
    .year    (in_tdata[36:23]),
    .month   (in_tdata[40:37]),
    .day     (in_tdata[45:41]),
    .day_num (start_num),
    .date_ok (start_ok)
  );

  // stage 4: order check and subtract
  logic               ok_nxt;
  logic [COUNT_W-1:0] count_r;
  logic               ok_r;

  assign ok_nxt = ref_ok && start_ok && (start_num <= ref_num);

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      count_r <= ok_nxt ? (ref_num - start_num) : '0;
      ok_r    <= ok_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {2'b00, count_r};
  assign out_tuser  = ok_r;

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[21:0] == '0))
    else $error("flagged transaction with nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[21:0] <= COUNT_MAX))
    else $error("day count out of range");

  a_ready_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(v1_r && v2_r && v3_r && v4_r && !out_tready))
    else $error("input ready with full stalled pipeline");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_tready) |=> v4_r)
    else $error("output lost during stall");

endmodule
`default_nettype wire
